FILE: rtl/escape_sequence_decoder_top_defines.svh
// Assertion macros used by the escape sequence decoder top level.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH

// Property checked at every rising clock edge, off while reset is asserted.
`define ESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/esd_pkg.sv
// Types and constants of the escape sequence decoder.
`timescale 1ns / 1ps
package esd_pkg;

  // Byte constants
  localparam logic [7:0] ESC_RESET = 8'h7C;  // '|'
  localparam logic [7:0] CHAR_N    = 8'h6E;
  localparam logic [7:0] CHAR_R    = 8'h72;
  localparam logic [7:0] CHAR_T    = 8'h74;
  localparam logic [7:0] CHAR_XL   = 8'h78;
  localparam logic [7:0] CHAR_XU   = 8'h58;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_AL   = 8'h61;
  localparam logic [7:0] CHAR_FL   = 8'h66;
  localparam logic [7:0] CHAR_AU   = 8'h41;
  localparam logic [7:0] CHAR_FU   = 8'h46;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  localparam logic [3:0] HEX_MAX = 4'd8;
  localparam logic [3:0] DEC_MAX = 4'd3;

  // Most bytes one input word can produce
  localparam int unsigned MAX_OUT = 5;

  typedef enum logic [4:0] {
    MODE_LIT   = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_XPEND = 5'b00100,
    MODE_HEX   = 5'b01000,
    MODE_DEC   = 5'b10000
  } esd_mode_e;

  // One classified input word: optional plain byte, code point, plain byte
  typedef struct packed {
    logic        pre_vld;
    logic [7:0]  pre_byte;
    logic        cp_vld;
    logic [31:0] cp;
    logic        post_vld;
    logic [7:0]  post_byte;
    logic        last;
  } esd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } esd_q_sts_t;

  typedef struct packed {
    logic mode_lit;
  } esd_fe_sts_t;

endpackage

FILE: rtl/esd_in_if.sv
// Input channel: escaped string bytes.
`timescale 1ns / 1ps
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

FILE: rtl/esd_out_if.sv
// Output channel: unescaped bytes.
`timescale 1ns / 1ps
interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_string;

  modport source (output valid, out_byte, last_of_run, end_of_string, input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_string, output ready);
endinterface

FILE: rtl/esd_front.sv
// Front end: accepts input words, tracks escape state, emits commands.
`timescale 1ns / 1ps
module esd_front import esd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  esd_in_if.sink       in_i,
  input  logic         q_full_i,
  output logic         push_o,
  output esd_cmd_t     cmd_o,
  output esd_fe_sts_t  sts_o
);

  esd_mode_e   mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  ndig_q, ndig_d;
  logic [7:0]  xbyte_q, xbyte_d;
  logic [7:0]  esc_q;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        is_dec;
  logic        is_hex;
  logic [3:0]  hval;
  logic [3:0]  ndig_inc;
  logic [31:0] hex_acc;
  logic [9:0]  dec_acc;
  esd_cmd_t    cmd;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign last       = in_i.last_byte;

  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      hval = b[3:0];
    end else if (b >= CHAR_AL && b <= CHAR_FL) begin
      hval = 4'(b - CHAR_AL + 8'd10);
    end else if (b >= CHAR_AU && b <= CHAR_FU) begin
      hval = 4'(b - CHAR_AU + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_dec   = (b >= CHAR_0) && (b <= CHAR_9);
  assign ndig_inc = ndig_q + 4'd1;
  assign hex_acc  = {acc_q[27:0], hval};
  // acc stays below 100 while decimal digits are still being taken
  assign dec_acc  = (acc_q[9:0] << 3) + (acc_q[9:0] << 1) + {6'd0, b[3:0]};

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    ndig_d  = ndig_q;
    xbyte_d = xbyte_q;
    cmd     = '0;
    cmd.last = last;

    // digit run closes first, then the byte may start something new
    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_LIT;
        if (b == CHAR_N) begin
          cmd.post_vld = 1'b1; cmd.post_byte = BYTE_LF;
        end else if (b == CHAR_R) begin
          cmd.post_vld = 1'b1; cmd.post_byte = BYTE_CR;
        end else if (b == CHAR_T) begin
          cmd.post_vld = 1'b1; cmd.post_byte = BYTE_TAB;
        end else if (b == CHAR_XL || b == CHAR_XU) begin
          if (last) begin
            cmd.post_vld = 1'b1; cmd.post_byte = b;
          end else begin
            xbyte_d = b;
            mode_d  = MODE_XPEND;
          end
        end else if (is_dec) begin
          if (last) begin
            cmd.cp_vld = 1'b1; cmd.cp = {28'd0, b[3:0]};
          end else begin
            acc_d  = {28'd0, b[3:0]};
            ndig_d = 4'd1;
            mode_d = MODE_DEC;
          end
        end else begin
          cmd.post_vld = 1'b1; cmd.post_byte = b;
        end
      end
      MODE_XPEND: begin
        mode_d = MODE_LIT;
        if (is_hex) begin
          if (last) begin
            cmd.cp_vld = 1'b1; cmd.cp = {28'd0, hval};
          end else begin
            acc_d  = {28'd0, hval};
            ndig_d = 4'd1;
            mode_d = MODE_HEX;
          end
        end else begin
          cmd.pre_vld  = 1'b1;
          cmd.pre_byte = xbyte_q;
          if (b == esc_q && !last) begin
            mode_d = MODE_ESC;
          end else begin
            cmd.post_vld = 1'b1; cmd.post_byte = b;
          end
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          if (ndig_inc >= HEX_MAX || last) begin
            cmd.cp_vld = 1'b1; cmd.cp = hex_acc;
            mode_d = MODE_LIT; acc_d = '0; ndig_d = '0;
          end else begin
            acc_d  = hex_acc;
            ndig_d = ndig_inc;
          end
        end else begin
          cmd.cp_vld = 1'b1; cmd.cp = acc_q;
          mode_d = MODE_LIT; acc_d = '0; ndig_d = '0;
          if (b == esc_q && !last) begin
            mode_d = MODE_ESC;
          end else begin
            cmd.post_vld = 1'b1; cmd.post_byte = b;
          end
        end
      end
      MODE_DEC: begin
        if (is_dec) begin
          if (ndig_inc >= DEC_MAX || last) begin
            cmd.cp_vld = 1'b1; cmd.cp = {22'd0, dec_acc};
            mode_d = MODE_LIT; acc_d = '0; ndig_d = '0;
          end else begin
            acc_d  = {22'd0, dec_acc};
            ndig_d = ndig_inc;
          end
        end else begin
          cmd.cp_vld = 1'b1; cmd.cp = acc_q;
          mode_d = MODE_LIT; acc_d = '0; ndig_d = '0;
          if (b == esc_q && !last) begin
            mode_d = MODE_ESC;
          end else begin
            cmd.post_vld = 1'b1; cmd.post_byte = b;
          end
        end
      end
      default: begin
        mode_d = MODE_LIT;
        if (b == esc_q && !last) begin
          mode_d = MODE_ESC;
        end else begin
          cmd.post_vld = 1'b1; cmd.post_byte = b;
        end
      end
    endcase

    if (last) begin
      mode_d  = MODE_LIT;
      acc_d   = '0;
      ndig_d  = '0;
      xbyte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LIT;
      acc_q   <= '0;
      ndig_q  <= '0;
      xbyte_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      ndig_q  <= ndig_d;
      xbyte_q <= xbyte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_RESET;
    end else if (cfg_we_i) begin
      esc_q <= cfg_wdata_i;
    end
  end

  assign push_o         = accept && (cmd.pre_vld || cmd.cp_vld || cmd.post_vld);
  assign cmd_o          = cmd;
  assign sts_o.mode_lit = (mode_q == MODE_LIT);

endmodule

FILE: rtl/esd_queue.sv
// Command queue between front end and back end.
`timescale 1ns / 1ps
module esd_queue import esd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  esd_cmd_t    push_cmd_i,
  input  logic        pop_i,
  output esd_cmd_t    head_cmd_o,
  output esd_q_sts_t  sts_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  esd_cmd_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign sts_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign do_push     = push_i && !sts_o.full;
  assign do_pop      = pop_i && !sts_o.empty;
  assign head_cmd_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/esd_back.sv
// Back end: expands commands into UTF-8 and plain bytes, one per cycle while the output is ready.
`timescale 1ns / 1ps
module esd_back import esd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  esd_cmd_t    head_cmd_i,
  input  logic        q_empty_i,
  output logic        pop_o,
  esd_out_if.source   out_o
);

  logic [7:0] obyte_q [MAX_OUT];
  logic [2:0] cnt_q;
  logic [2:0] idx_q;
  logic       last_q;
  logic       vld_q;

  logic [7:0] enc [4];
  logic [2:0] enc_n;
  logic [7:0] exp_byte [MAX_OUT];
  logic [2:0] exp_n;
  logic [31:0] cp;
  logic       at_end;
  logic       out_hs;

  assign cp = head_cmd_i.cp;

  // UTF-8 encode the code point
  always_comb begin
    enc[0] = '0; enc[1] = '0; enc[2] = '0; enc[3] = '0;
    if (cp < 32'h80) begin
      enc[0] = cp[7:0];
      enc_n  = 3'd1;
    end else if (cp < 32'h800) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      enc_n  = 3'd2;
    end else if (cp < 32'h10000) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      enc_n  = 3'd3;
    end else if (cp <= 32'h10FFFF) begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      enc_n  = 3'd4;
    end else begin
      // out of range: replacement character
      enc[0] = 8'hEF;
      enc[1] = 8'hBF;
      enc[2] = 8'hBD;
      enc_n  = 3'd3;
    end
  end

  // pack pre byte, code point bytes and post byte into slots
  always_comb begin
    for (int i = 0; i < MAX_OUT; i++) begin
      exp_byte[i] = '0;
    end
    exp_n = '0;
    if (head_cmd_i.pre_vld) begin
      exp_byte[exp_n] = head_cmd_i.pre_byte;
      exp_n = exp_n + 3'd1;
    end
    if (head_cmd_i.cp_vld) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < enc_n) begin
          exp_byte[exp_n] = enc[i];
          exp_n = exp_n + 3'd1;
        end
      end
    end
    if (head_cmd_i.post_vld) begin
      exp_byte[exp_n] = head_cmd_i.post_byte;
      exp_n = exp_n + 3'd1;
    end
  end

  assign at_end = (idx_q == cnt_q - 3'd1);
  assign out_hs = out_o.valid && out_o.ready;
  assign pop_o  = !q_empty_i && (!vld_q || (out_hs && at_end));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < MAX_OUT; i++) begin
        obyte_q[i] <= exp_byte[i];
      end
      cnt_q  <= exp_n;
      last_q <= head_cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (out_hs) begin
      if (at_end) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.out_byte      = obyte_q[idx_q];
  assign out_o.last_of_run   = at_end;
  assign out_o.end_of_string = at_end && last_q;

endmodule

FILE: rtl/escape_sequence_decoder_top.sv
// Escape sequence decoder top level: front end, command queue, back end.
// Output bytes of an input word pass through the command queue and the back-end register.
// Throughput: one input word per cycle while the queue has room, one output byte per cycle
// while out_o is ready; a numeric escape yields up to five bytes, absorbed by the QUEUE_DEPTH-entry command queue.
// Reset (async, active low): literal mode, escape byte '|', queue and output empty.
`timescale 1ns / 1ps
`include "escape_sequence_decoder_top_defines.svh"
module escape_sequence_decoder_top import esd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  esd_in_if.sink     in_i,
  esd_out_if.source  out_o
);

  // Front end -> queue: one command per input word that makes output.
  // Words that only change state (an escape byte, a digit inside a run)
  // push nothing.
  logic        push;
  esd_cmd_t    push_cmd;
  esd_fe_sts_t fe_sts;

  // Queue -> back end
  esd_cmd_t    head_cmd;
  esd_q_sts_t  q_sts;
  logic        pop;

  // Decode state machine and escape byte register; ready while queue has room
  esd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_sts.full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .sts_o       (fe_sts)
  );

  // Decouples the front, one word per cycle while the queue has room, from multi-byte expansions
  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .sts_o      (q_sts)
  );

  // UTF-8 encoding and byte sequencing; loads the next command while the
  // last byte of the current one is taken, so single bytes stream at full rate
  esd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_cmd_i (head_cmd),
    .q_empty_i  (q_sts.empty),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // Checks
  `ESD_ASSERT(a_no_push_full, push |-> !q_sts.full, "command pushed into full queue")
  `ESD_ASSERT(a_no_pop_empty, pop |-> !q_sts.empty, "command popped from empty queue")
  `ESD_ASSERT_NEXT(a_last_resets, in_i.valid && in_i.ready && in_i.last_byte, fe_sts.mode_lit, "decoder not in literal mode after final byte")
  `ESD_ASSERT(a_eos_is_run_end, out_o.valid && out_o.end_of_string |-> out_o.last_of_run, "end of string not on last byte of run")

endmodule
